// ----- hw/rtl/rgb_pwm_gamma_brightness_assert.svh -----
// Assertion macros for the RGB PWM block, with an empty variant for builds without checks.
`ifndef RGB_PWM_GAMMA_BRIGHTNESS_ASSERT_SVH
`define RGB_PWM_GAMMA_BRIGHTNESS_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define RPG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgb_pwm_gamma_brightness: same-cycle check failed");
// Next-cycle implication.
`define RPG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgb_pwm_gamma_brightness: next-cycle check failed");
`else
`define RPG_ASSERT_NOW(lbl, ante, cons)
`define RPG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/rgbpwm_pkg.sv -----
// Shared types, codes and helpers of the RGB PWM block.
package rgbpwm_pkg;

	localparam int LEVEL_W  = 9;
	localparam int CHANNELS = 3;
	localparam int CH_W     = 2;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [CH_W-1:0]    chan_t;

	localparam level_t LEVEL_MAX = 9'd256;

	// Item codes.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	// Channel indexes.
	localparam chan_t CH_RED   = 2'd0;
	localparam chan_t CH_GREEN = 2'd1;
	localparam chan_t CH_BLUE  = 2'd2;

	// Write of one reload level from the scaler.
	typedef struct packed {
		logic   we;
		chan_t  ch;
		level_t level;
	} lvl_wr_t;

	// Clamp a 9-bit request to the full-scale level.
	function automatic level_t sat_level(input level_t v);
		sat_level = (v > LEVEL_MAX) ? LEVEL_MAX : v;
	endfunction

endpackage

// ----- hw/rtl/rgbpwm_in_if.sv -----
// Input channel: valid/ready handshake carrying one tick or set-colour item.
interface rgbpwm_in_if import rgbpwm_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   op;
	level_t red;
	level_t green;
	level_t blue;
	level_t brightness;

	modport source (output valid, output op, output red, output green, output blue,
		output brightness, input ready);
	modport sink (input valid, input op, input red, input green, input blue,
		input brightness, output ready);
endinterface

// ----- hw/rtl/rgbpwm_out_if.sv -----
// Output channel: valid/ready handshake carrying the pin levels after each item.
interface rgbpwm_out_if;
	logic valid;
	logic ready;
	logic pin_red;
	logic pin_green;
	logic pin_blue;
	logic period_start;

	modport source (output valid, output pin_red, output pin_green, output pin_blue,
		output period_start, input ready);
	modport sink (input valid, input pin_red, input pin_green, input pin_blue,
		input period_start, output ready);
endinterface

// ----- hw/rtl/rgb_pwm_gamma_brightness.sv -----
// Three-channel active-low LED PWM with cubic gamma and brightness scaling.
// The result of every item is registered and shown in the cycle after its input transfer.
// Tick items can arrive back to back while the output side keeps taking results.
// A set-colour item holds the input off while the scaler runs: three multiplies on the shared
// multiplier and one write for each of the three channels. Reset: counter at 256, levels zero,
// pins high.
`include "rgb_pwm_gamma_brightness_assert.svh"

module rgb_pwm_gamma_brightness import rgbpwm_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	rgbpwm_in_if.sink    in_ch,
	rgbpwm_out_if.source out_ch
);

	// Period counter runs 256 down to 0; the zero tick starts a new period.
	level_t     cnt_q;
	level_t     act_q [CHANNELS];
	level_t     rel_q [CHANNELS];
	logic [2:0] pin_q;
	logic       start_q;
	logic       out_valid_q;

	logic    in_xfer;
	logic    scl_busy;
	logic    scl_start;
	lvl_wr_t scl_wr;

	// An item is taken when the scaler is free and the result slot is empty or
	// being emptied in the same cycle. Pin state only moves on an input transfer,
	// so a stalled result holds steady without a separate copy.
	assign in_ch.ready = !scl_busy && (!out_valid_q || out_ch.ready);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign scl_start   = in_xfer && (in_ch.op == OP_SET);

	// The scaler computes the three reload levels one multiply at a time.
	rgbpwm_scaler u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scl_start),
		.red    (sat_level(in_ch.red)),
		.green  (sat_level(in_ch.green)),
		.blue   (sat_level(in_ch.blue)),
		.bright (sat_level(in_ch.brightness)),
		.busy   (scl_busy),
		.wr     (scl_wr)
	);

	// Reload levels are written by the scaler while no tick can be accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				rel_q[i] <= '0;
			end
		end else if (scl_wr.we) begin
			case (scl_wr.ch)
				CH_RED:   rel_q[0] <= scl_wr.level;
				CH_GREEN: rel_q[1] <= scl_wr.level;
				default:  rel_q[2] <= scl_wr.level;
			endcase
		end
	end

	// PWM period logic, moved by tick items. A zero count reloads, latches new levels and turns all
	// LEDs off; otherwise a pin goes low when the count meets its level.
	// A level of zero is never met because the count is never compared at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= LEVEL_MAX;
			pin_q   <= 3'b111;
			start_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				act_q[i] <= '0;
			end
		end else if (in_xfer) begin
			if (in_ch.op == OP_SET) begin
				start_q <= 1'b0;
			end else if (cnt_q == '0) begin
				cnt_q   <= LEVEL_MAX;
				pin_q   <= 3'b111;
				start_q <= 1'b1;
				for (int i = 0; i < CHANNELS; i++) begin
					act_q[i] <= rel_q[i];
				end
			end else begin
				start_q <= 1'b0;
				cnt_q   <= cnt_q - 9'd1;
				for (int i = 0; i < CHANNELS; i++) begin
					if (cnt_q == act_q[i]) begin
						pin_q[i] <= 1'b0;
					end
				end
			end
		end
	end

	// Result slot: filled by each input transfer, emptied by an output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.pin_red      = pin_q[0];
	assign out_ch.pin_green    = pin_q[1];
	assign out_ch.pin_blue     = pin_q[2];
	assign out_ch.period_start = start_q;

	// The input is never taken while the scaler is still writing levels.
	`RPG_ASSERT_NOW(a_no_take_while_busy, in_ch.ready, !scl_busy && !scl_wr.we)
	// A set-colour transfer keeps the scaler busy in the following cycle.
	`RPG_ASSERT_NEXT(a_set_starts_scaler, scl_start, scl_busy)
	// A period start always reports every LED off.
	`RPG_ASSERT_NOW(a_start_all_high, out_valid_q && start_q,
		pin_q[0] && pin_q[1] && pin_q[2])
	// The counter stays within the period range.
	`RPG_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= LEVEL_MAX)

endmodule

// ----- hw/rtl/rgbpwm_scaler.sv -----
// Iterative gamma and brightness scaler built around one shared multiplier.
module rgbpwm_scaler import rgbpwm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  level_t  red,
	input  level_t  green,
	input  level_t  blue,
	input  level_t  bright,
	output logic    busy,
	output lvl_wr_t wr
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	localparam logic [1:0] STEP_SQUARE = 2'd0;
	localparam logic [1:0] STEP_CUBE   = 2'd1;
	localparam logic [1:0] STEP_SCALE  = 2'd2;
	localparam logic [1:0] STEP_WRITE  = 2'd3;

	localparam chan_t LAST_CH = chan_t'(CHANNELS - 1);

	logic        state_q;
	logic [1:0]  step_q;
	chan_t       ch_q;
	level_t      col_q [CHANNELS];
	level_t      bright_q;
	logic [24:0] prod_q;

	level_t      col_sel;
	logic [9:0]  gamma_rnd;
	level_t      gamma;
	logic [16:0] mul_a;
	level_t      mul_b;
	logic [25:0] mul_p;

	always_comb begin
		case (ch_q)
			CH_RED:   col_sel = col_q[0];
			CH_GREEN: col_sel = col_q[1];
			default:  col_sel = col_q[2];
		endcase
	end

	// Cube scaled down by 2^16 with rounding; at most 256.
	assign gamma_rnd = prod_q[24:15] + 10'd1;
	assign gamma     = gamma_rnd[9:1];

	always_comb begin
		case (step_q)
			STEP_SQUARE: begin
				mul_a = {8'd0, col_sel};
				mul_b = col_sel;
			end
			STEP_CUBE: begin
				mul_a = prod_q[16:0];
				mul_b = col_sel;
			end
			default: begin
				mul_a = {8'd0, gamma};
				mul_b = bright_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_SQUARE;
			ch_q    <= CH_RED;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						step_q  <= STEP_SQUARE;
						ch_q    <= CH_RED;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 2'd1;
					if (step_q == STEP_WRITE) begin
						if (ch_q == LAST_CH) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q <= ch_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			col_q[0] <= red;
			col_q[1] <= green;
			col_q[2] <= blue;
			bright_q <= bright;
		end
		if (state_q == ST_RUN && step_q != STEP_WRITE) begin
			prod_q <= mul_p[24:0];
		end
	end

	assign busy     = (state_q == ST_RUN);
	assign wr.we    = (state_q == ST_RUN) && (step_q == STEP_WRITE);
	assign wr.ch    = ch_q;
	assign wr.level = prod_q[16:8];

endmodule
